### rtl/bsc_pkg.sv
// Shared types and constants for the barometric sensor compensation block.
// No dependencies; used by bsc_div and barometric_sensor_compensation.
package bsc_pkg;

   // Pipelined divider geometry
   localparam int DIV_NUM_W  = 32;
   localparam int DIV_DEN_W  = 19;
   localparam int DIV_STAGES = DIV_NUM_W;

   // Total register stages from input accept to result register
   localparam int LATENCY = 2 * DIV_STAGES + 17;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_TEMP_CAL     = 2'd0,
      CSR_PRESS_CAL_A  = 2'd1,
      CSR_PRESS_CAL_B  = 2'd2,
      CSR_OVERSAMPLING = 2'd3
   } csr_index_type;

   // Compensation constants
   localparam logic [1:0]         OSS_RESET  = 2'd1;
   localparam logic signed [27:0] B6_OFFSET  = 28'sd4000;
   localparam logic [11:0]        P_C1       = 12'd3038;
   localparam logic [12:0]        P_C2       = 13'd7357;
   localparam logic signed [47:0] P_C3       = 48'sd3791;
   localparam logic [15:0]        B7_SCALE   = 16'd50000;
   localparam logic [31:0]        B4_OFFSET  = 32'd32768;

   // Output saturation limits
   localparam logic signed [23:0] T_MIN = -24'sd4096;
   localparam logic signed [23:0] T_MAX = 24'sd4095;
   localparam logic signed [48:0] P_MAX = 49'sd262143;

endpackage

### rtl/bsc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on bsc_pkg for widths and stage count.
module bsc_div (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [bsc_pkg::DIV_NUM_W-1:0]  num,
   input  logic [bsc_pkg::DIV_DEN_W-1:0]  den,
   output logic [bsc_pkg::DIV_NUM_W-1:0]  quo
);

   logic [bsc_pkg::DIV_NUM_W-1:0] nq_ff  [bsc_pkg::DIV_STAGES];
   logic [bsc_pkg::DIV_NUM_W-1:0] nq_in  [bsc_pkg::DIV_STAGES];
   logic [bsc_pkg::DIV_DEN_W-1:0] rem_ff [bsc_pkg::DIV_STAGES];
   logic [bsc_pkg::DIV_DEN_W-1:0] rem_in [bsc_pkg::DIV_STAGES];
   logic [bsc_pkg::DIV_DEN_W-1:0] den_ff [bsc_pkg::DIV_STAGES];
   logic [bsc_pkg::DIV_DEN_W-1:0] den_in [bsc_pkg::DIV_STAGES];

   // Each stage shifts in one numerator bit and tries a subtract
   always_comb begin
      logic [bsc_pkg::DIV_NUM_W-1:0] nq_src;
      logic [bsc_pkg::DIV_DEN_W-1:0] rem_src;
      logic [bsc_pkg::DIV_DEN_W-1:0] den_src;
      logic [bsc_pkg::DIV_DEN_W:0]   shifted;
      logic [bsc_pkg::DIV_DEN_W+1:0] trial;
      for (int k = 0; k < bsc_pkg::DIV_STAGES; k++) begin
         if (k == 0) begin
            nq_src  = num;
            rem_src = '0;
            den_src = den;
         end else begin
            nq_src  = nq_ff[k-1];
            rem_src = rem_ff[k-1];
            den_src = den_ff[k-1];
         end
         shifted   = {rem_src, nq_src[bsc_pkg::DIV_NUM_W-1]};
         trial     = {1'b0, shifted} - {2'b00, den_src};
         den_in[k] = den_src;
         if (!trial[bsc_pkg::DIV_DEN_W+1]) begin
            rem_in[k] = trial[bsc_pkg::DIV_DEN_W-1:0];
            nq_in[k]  = {nq_src[bsc_pkg::DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in[k] = shifted[bsc_pkg::DIV_DEN_W-1:0];
            nq_in[k]  = {nq_src[bsc_pkg::DIV_NUM_W-2:0], 1'b0};
         end
      end
   end

   // Advance all stages together; hold on stall
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < bsc_pkg::DIV_STAGES; k++) begin
            nq_ff[k]  <= nq_in[k];
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_in[k];
         end
      end
   end

   assign quo = nq_ff[bsc_pkg::DIV_STAGES-1];

endmodule

### rtl/barometric_sensor_compensation.sv
// Barometric sensor compensation: raw temperature and pressure to 0.1 deg and pascals.
// Latency: 81 register stages (two 32-stage dividers plus logic), from the register
// that the accepting edge loads with an input item up to the result register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, clears valid bits and loads the calibration registers with
// zero and oversampling with 1. Depends on bsc_pkg and bsc_div.
module barometric_sensor_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_raw_temperature,
   input  logic [18:0]        req_raw_pressure,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [12:0] rsp_temperature_tenths,
   output logic [17:0]        rsp_pressure_pa,
   output logic               rsp_divide_error,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   localparam int DS = bsc_pkg::DIV_STAGES;

   // Configuration registers
   logic [63:0] temp_cal_ff;
   logic [63:0] press_cal_a_ff;
   logic [31:0] press_cal_b_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff    <= '0;
         press_cal_a_ff <= '0;
         press_cal_b_ff <= '0;
         oss_ff         <= bsc_pkg::OSS_RESET;
      end else if (csr_we) begin
         case (bsc_pkg::csr_index_type'(csr_index))
            bsc_pkg::CSR_TEMP_CAL:     temp_cal_ff    <= csr_wdata;
            bsc_pkg::CSR_PRESS_CAL_A:  press_cal_a_ff <= csr_wdata;
            bsc_pkg::CSR_PRESS_CAL_B:  press_cal_b_ff <= csr_wdata[31:0];
            bsc_pkg::CSR_OVERSAMPLING: oss_ff         <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Calibration fields
   logic [15:0]        ac5, ac6, ac4;
   logic signed [15:0] mc, md, ac1, ac2, ac3, b1, b2;
   assign ac5 = temp_cal_ff[63:48];
   assign ac6 = temp_cal_ff[47:32];
   assign mc  = temp_cal_ff[31:16];
   assign md  = temp_cal_ff[15:0];
   assign ac1 = press_cal_a_ff[63:48];
   assign ac2 = press_cal_a_ff[47:32];
   assign ac3 = press_cal_a_ff[31:16];
   assign ac4 = press_cal_a_ff[15:0];
   assign b1  = press_cal_b_ff[31:16];
   assign b2  = press_cal_b_ff[15:0];

   // Global stall: hold everything while the result register is full and not taken
   logic advance;
   logic vld_ff [bsc_pkg::LATENCY];
   assign advance   = !vld_ff[bsc_pkg::LATENCY-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[bsc_pkg::LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < bsc_pkg::LATENCY; k++) vld_ff[k] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < bsc_pkg::LATENCY; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // ---------------- S1: (UT - ac6) * ac5
   logic signed [16:0] diff_in;
   logic signed [33:0] s1_prod_in;
   logic signed [33:0] s1_prod_ff;
   logic [18:0]        s1_up_ff;
   assign diff_in    = $signed({1'b0, req_raw_temperature}) - $signed({1'b0, ac6});
   assign s1_prod_in = diff_in * $signed({1'b0, ac5});

   // ---------------- S2: X1 and the temperature divisor
   logic signed [17:0] x1t;
   logic signed [18:0] s2_d1_in;
   logic signed [17:0] s2_x1_ff;
   logic signed [18:0] s2_d1_ff;
   logic [18:0]        s2_up_ff;
   assign x1t      = s1_prod_ff[32:15];
   assign s2_d1_in = {x1t[17], x1t} + {{3{md[15]}}, md};

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff <= s1_prod_in;
         s1_up_ff   <= req_raw_pressure;
         s2_x1_ff   <= x1t;
         s2_d1_ff   <= s2_d1_in;
         s2_up_ff   <= s1_up_ff;
      end
   end

   // Temperature divide: (mc * 2048) / (X1 + md) on magnitudes
   logic [18:0] d1_mag;
   logic [16:0] mc_mag;
   logic [31:0] dt_num;
   logic [31:0] dt_quo;
   assign d1_mag = s2_d1_ff[18] ? 19'(-s2_d1_ff) : 19'(s2_d1_ff);
   assign mc_mag = mc[15] ? 17'(-{mc[15], mc}) : {1'b0, mc};
   assign dt_num = {4'b0, mc_mag, 11'b0};

   bsc_div u_div_t (
      .clock  (clock),
      .enable (advance),
      .num    (dt_num),
      .den    (d1_mag),
      .quo    (dt_quo)
   );

   // Carry side data alongside the divider
   logic signed [17:0] dt_x1_ff   [DS];
   logic               dt_zero_ff [DS];
   logic               dt_neg_ff  [DS];
   logic [18:0]        dt_up_ff   [DS];

   always_ff @(posedge clock) begin
      if (advance) begin
         dt_x1_ff[0]   <= s2_x1_ff;
         dt_zero_ff[0] <= (s2_d1_ff == 19'sd0);
         dt_neg_ff[0]  <= mc[15] ^ s2_d1_ff[18];
         dt_up_ff[0]   <= s2_up_ff;
         for (int k = 1; k < DS; k++) begin
            dt_x1_ff[k]   <= dt_x1_ff[k-1];
            dt_zero_ff[k] <= dt_zero_ff[k-1];
            dt_neg_ff[k]  <= dt_neg_ff[k-1];
            dt_up_ff[k]   <= dt_up_ff[k-1];
         end
      end
   end

   // ---------------- S3: B5 = X1 + X2
   logic signed [27:0] x2t;
   logic signed [27:0] s3_b5_in;
   logic signed [27:0] s3_b5_ff;
   logic [18:0]        s3_up_ff;
   logic               s3_err_ff;
   assign x2t = dt_neg_ff[DS-1] ? -$signed({1'b0, dt_quo[26:0]}) : $signed({1'b0, dt_quo[26:0]});
   assign s3_b5_in = {{10{dt_x1_ff[DS-1][17]}}, dt_x1_ff[DS-1]} + x2t;

   // ---------------- S4: B6 and saturated temperature
   logic signed [27:0] t_round;
   logic signed [23:0] t_shift;
   logic signed [12:0] s4_t_in;
   logic signed [27:0] s4_b6_ff;
   logic signed [12:0] s4_t_ff;
   logic [18:0]        s4_up_ff;
   logic               s4_err_ff;
   assign t_round = s3_b5_ff + 28'sd8;
   assign t_shift = t_round[27:4];

   always_comb begin
      if (t_shift < bsc_pkg::T_MIN) begin
         s4_t_in = 13'(bsc_pkg::T_MIN);
      end else if (t_shift > bsc_pkg::T_MAX) begin
         s4_t_in = 13'(bsc_pkg::T_MAX);
      end else begin
         s4_t_in = t_shift[12:0];
      end
   end

   // ---------------- S5: B6 squared and coefficient products
   logic signed [55:0] b6sq_full;
   logic signed [43:0] ac2b6_in, ac3b6_in;
   logic [54:0]        s5_b6sq_ff;
   logic signed [43:0] s5_ac2b6_ff, s5_ac3b6_ff;
   logic signed [12:0] s5_t_ff;
   logic [18:0]        s5_up_ff;
   logic               s5_err_ff;
   assign b6sq_full = s4_b6_ff * s4_b6_ff;
   assign ac2b6_in  = ac2 * s4_b6_ff;
   assign ac3b6_in  = ac3 * s4_b6_ff;

   // ---------------- S6: split (B6^2 >> 12) into halves for b1 and b2 products
   logic [42:0]        sq;
   logic signed [38:0] pp_b2_lo_in, pp_b1_lo_in;
   logic signed [37:0] pp_b2_hi_in, pp_b1_hi_in;
   logic signed [38:0] s6_b2_lo_ff, s6_b1_lo_ff;
   logic signed [37:0] s6_b2_hi_ff, s6_b1_hi_ff;
   logic signed [32:0] s6_x2a_ff;
   logic signed [30:0] s6_x1c_ff;
   logic signed [12:0] s6_t_ff;
   logic [18:0]        s6_up_ff;
   logic               s6_err_ff;
   assign sq          = s5_b6sq_ff[54:12];
   assign pp_b2_lo_in = b2 * $signed({1'b0, sq[21:0]});
   assign pp_b2_hi_in = b2 * $signed({1'b0, sq[42:22]});
   assign pp_b1_lo_in = b1 * $signed({1'b0, sq[21:0]});
   assign pp_b1_hi_in = b1 * $signed({1'b0, sq[42:22]});

   // ---------------- S7: recombine partial products
   logic signed [59:0] s7_b2sq_in, s7_b1sq_in;
   logic signed [59:0] s7_b2sq_ff, s7_b1sq_ff;
   logic signed [32:0] s7_x2a_ff;
   logic signed [30:0] s7_x1c_ff;
   logic signed [12:0] s7_t_ff;
   logic [18:0]        s7_up_ff;
   logic               s7_err_ff;
   assign s7_b2sq_in = $signed({s6_b2_hi_ff, 22'b0}) + {{21{s6_b2_lo_ff[38]}}, s6_b2_lo_ff};
   assign s7_b1sq_in = $signed({s6_b1_hi_ff, 22'b0}) + {{21{s6_b1_lo_ff[38]}}, s6_b1_lo_ff};

   // ---------------- S8: X3 for B3 and the low bits of X1 + X2 + 2 for B4
   logic signed [49:0] s8_x3b_in;
   logic [33:0]        s8_x34_in;
   logic signed [49:0] s8_x3b_ff;
   logic [33:0]        s8_x34_ff;
   logic signed [12:0] s8_t_ff;
   logic [18:0]        s8_up_ff;
   logic               s8_err_ff;
   assign s8_x3b_in = {s7_b2sq_ff[59], s7_b2sq_ff[59:11]} + {{17{s7_x2a_ff[32]}}, s7_x2a_ff};
   assign s8_x34_in = {{3{s7_x1c_ff[30]}}, s7_x1c_ff} + s7_b1sq_ff[49:16] + 34'd2;

   // ---------------- S9: ac1 * 4 + X3, and (X3 + 32768) mod 2^32
   logic signed [51:0] s9_w_in;
   logic [31:0]        s9_x3p_in;
   logic signed [51:0] s9_w_ff;
   logic [31:0]        s9_x3p_ff;
   logic signed [12:0] s9_t_ff;
   logic [18:0]        s9_up_ff;
   logic               s9_err_ff;
   assign s9_w_in   = {{34{ac1[15]}}, ac1, 2'b00} + {{2{s8_x3b_ff[49]}}, s8_x3b_ff};
   assign s9_x3p_in = s8_x34_ff[33:2] + bsc_pkg::B4_OFFSET;

   // ---------------- S10: scale by oversampling, and ac4 product
   logic signed [54:0] s10_v_in;
   logic [47:0]        b4m_full;
   logic signed [54:0] s10_v_ff;
   logic [31:0]        s10_b4m_ff;
   logic signed [12:0] s10_t_ff;
   logic [18:0]        s10_up_ff;
   logic               s10_err_ff;
   assign s10_v_in = ($signed({{3{s9_w_ff[51]}}, s9_w_ff}) <<< oss_ff) + 55'sd2;
   assign b4m_full = ac4 * s9_x3p_ff;

   // ---------------- S11: B3 (divide by 4 toward zero, low 32 bits) and B4
   logic [33:0]        b3_adj;
   logic [31:0]        s11_b3_ff;
   logic [16:0]        s11_b4_ff;
   logic signed [12:0] s11_t_ff;
   logic [18:0]        s11_up_ff;
   logic               s11_err_ff;
   assign b3_adj = s10_v_ff[33:0] + (s10_v_ff[54] ? 34'd3 : 34'd0);

   // ---------------- S12: UP - B3
   logic [31:0]        s12_b7a_ff;
   logic [16:0]        s12_b4_ff;
   logic signed [12:0] s12_t_ff;
   logic               s12_err_ff;

   // ---------------- S13: B7 and the zero-divisor check
   logic [47:0]        b7_full;
   logic [31:0]        s13_b7_ff;
   logic [16:0]        s13_b4_ff;
   logic signed [12:0] s13_t_ff;
   logic               s13_err_ff;
   assign b7_full = s12_b7a_ff * (bsc_pkg::B7_SCALE >> oss_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_b5_ff    <= s3_b5_in;
         s3_up_ff    <= dt_up_ff[DS-1];
         s3_err_ff   <= dt_zero_ff[DS-1];
         s4_b6_ff    <= s3_b5_ff - bsc_pkg::B6_OFFSET;
         s4_t_ff     <= s4_t_in;
         s4_up_ff    <= s3_up_ff;
         s4_err_ff   <= s3_err_ff;
         s5_b6sq_ff  <= b6sq_full[54:0];
         s5_ac2b6_ff <= ac2b6_in;
         s5_ac3b6_ff <= ac3b6_in;
         s5_t_ff     <= s4_t_ff;
         s5_up_ff    <= s4_up_ff;
         s5_err_ff   <= s4_err_ff;
         s6_b2_lo_ff <= pp_b2_lo_in;
         s6_b2_hi_ff <= pp_b2_hi_in;
         s6_b1_lo_ff <= pp_b1_lo_in;
         s6_b1_hi_ff <= pp_b1_hi_in;
         s6_x2a_ff   <= s5_ac2b6_ff[43:11];
         s6_x1c_ff   <= s5_ac3b6_ff[43:13];
         s6_t_ff     <= s5_t_ff;
         s6_up_ff    <= s5_up_ff;
         s6_err_ff   <= s5_err_ff;
         s7_b2sq_ff  <= s7_b2sq_in;
         s7_b1sq_ff  <= s7_b1sq_in;
         s7_x2a_ff   <= s6_x2a_ff;
         s7_x1c_ff   <= s6_x1c_ff;
         s7_t_ff     <= s6_t_ff;
         s7_up_ff    <= s6_up_ff;
         s7_err_ff   <= s6_err_ff;
         s8_x3b_ff   <= s8_x3b_in;
         s8_x34_ff   <= s8_x34_in;
         s8_t_ff     <= s7_t_ff;
         s8_up_ff    <= s7_up_ff;
         s8_err_ff   <= s7_err_ff;
         s9_w_ff     <= s9_w_in;
         s9_x3p_ff   <= s9_x3p_in;
         s9_t_ff     <= s8_t_ff;
         s9_up_ff    <= s8_up_ff;
         s9_err_ff   <= s8_err_ff;
         s10_v_ff    <= s10_v_in;
         s10_b4m_ff  <= b4m_full[31:0];
         s10_t_ff    <= s9_t_ff;
         s10_up_ff   <= s9_up_ff;
         s10_err_ff  <= s9_err_ff;
         s11_b3_ff   <= b3_adj[33:2];
         s11_b4_ff   <= s10_b4m_ff[31:15];
         s11_t_ff    <= s10_t_ff;
         s11_up_ff   <= s10_up_ff;
         s11_err_ff  <= s10_err_ff;
         s12_b7a_ff  <= {13'b0, s11_up_ff} - s11_b3_ff;
         s12_b4_ff   <= s11_b4_ff;
         s12_t_ff    <= s11_t_ff;
         s12_err_ff  <= s11_err_ff;
         s13_b7_ff   <= b7_full[31:0];
         s13_b4_ff   <= s12_b4_ff;
         s13_t_ff    <= s12_t_ff;
         s13_err_ff  <= s12_err_ff || (s12_b4_ff == 17'd0);
      end
   end

   // Pressure divide: B7 * 2 / B4, or (B7 / B4) * 2 when B7 has its top bit set
   logic [31:0] dp_num;
   logic [31:0] dp_quo;
   assign dp_num = s13_b7_ff[31] ? s13_b7_ff : {s13_b7_ff[30:0], 1'b0};

   bsc_div u_div_p (
      .clock  (clock),
      .enable (advance),
      .num    (dp_num),
      .den    ({2'b00, s13_b4_ff}),
      .quo    (dp_quo)
   );

   logic               dp_dbl_ff [DS];
   logic signed [12:0] dp_t_ff   [DS];
   logic               dp_err_ff [DS];

   always_ff @(posedge clock) begin
      if (advance) begin
         dp_dbl_ff[0] <= s13_b7_ff[31];
         dp_t_ff[0]   <= s13_t_ff;
         dp_err_ff[0] <= s13_err_ff;
         for (int k = 1; k < DS; k++) begin
            dp_dbl_ff[k] <= dp_dbl_ff[k-1];
            dp_t_ff[k]   <= dp_t_ff[k-1];
            dp_err_ff[k] <= dp_err_ff[k-1];
         end
      end
   end

   // ---------------- Sa: p, (p >> 8)^2 and 7357 * p
   logic [32:0]        p_in;
   logic [49:0]        sa_sqp_in;
   logic [45:0]        sa_m2_in;
   logic [32:0]        sa_p_ff;
   logic [49:0]        sa_sqp_ff;
   logic [45:0]        sa_m2_ff;
   logic signed [12:0] sa_t_ff;
   logic               sa_err_ff;
   assign p_in      = dp_dbl_ff[DS-1] ? {dp_quo, 1'b0} : {1'b0, dp_quo};
   assign sa_sqp_in = p_in[32:8] * p_in[32:8];
   assign sa_m2_in  = p_in * bsc_pkg::P_C2;

   // ---------------- Sb: X1 = (sq * 3038) >> 16, X2 = (-7357 * p) >> 16
   logic [61:0]        x1m_full;
   logic signed [46:0] m2_neg;
   logic [45:0]        sb_x1_ff;
   logic signed [30:0] sb_x2_ff;
   logic [32:0]        sb_p_ff;
   logic signed [12:0] sb_t_ff;
   logic               sb_err_ff;
   assign x1m_full = sa_sqp_ff * bsc_pkg::P_C1;
   assign m2_neg   = -$signed({1'b0, sa_m2_ff});

   // ---------------- Sc: X1 + X2 + 3791
   logic signed [47:0] sc_s_in;
   logic signed [47:0] sc_s_ff;
   logic [32:0]        sc_p_ff;
   logic signed [12:0] sc_t_ff;
   logic               sc_err_ff;
   assign sc_s_in = $signed({2'b00, sb_x1_ff}) + {{17{sb_x2_ff[30]}}, sb_x2_ff} + bsc_pkg::P_C3;

   // ---------------- Sd: final pressure, saturate, zero on divide error
   logic signed [48:0] p_final;
   logic [17:0]        p_sat;
   assign p_final = $signed({16'b0, sc_p_ff}) + {{5{sc_s_ff[47]}}, sc_s_ff[47:4]};

   always_comb begin
      if (p_final < 49'sd0) begin
         p_sat = '0;
      end else if (p_final > bsc_pkg::P_MAX) begin
         p_sat = 18'(bsc_pkg::P_MAX);
      end else begin
         p_sat = p_final[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sa_p_ff   <= p_in;
         sa_sqp_ff <= sa_sqp_in;
         sa_m2_ff  <= sa_m2_in;
         sa_t_ff   <= dp_t_ff[DS-1];
         sa_err_ff <= dp_err_ff[DS-1];
         sb_x1_ff  <= x1m_full[61:16];
         sb_x2_ff  <= m2_neg[46:16];
         sb_p_ff   <= sa_p_ff;
         sb_t_ff   <= sa_t_ff;
         sb_err_ff <= sa_err_ff;
         sc_s_ff   <= sc_s_in;
         sc_p_ff   <= sb_p_ff;
         sc_t_ff   <= sb_t_ff;
         sc_err_ff <= sb_err_ff;
         rsp_divide_error       <= sc_err_ff;
         rsp_temperature_tenths <= sc_err_ff ? 13'sd0 : sc_t_ff;
         rsp_pressure_pa        <= sc_err_ff ? 18'd0 : p_sat;
      end
   end

endmodule
